[rtl/givens_hessenberg_column_update_assert.svh]
// Assertion macros for the file that checks this block.
`ifndef GIVENS_HESSENBERG_COLUMN_UPDATE_ASSERT_SVH
`define GIVENS_HESSENBERG_COLUMN_UPDATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GHC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ghc_pkg.sv]
package ghc_pkg;

    // One input item.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
    } ghc_in_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] entry;
        logic [4:0]         row;
        logic signed [31:0] rhs_entry;
        logic [30:0]        residual;
        logic               column_end;
        logic [1:0]         status;
    } ghc_out_t;

    // Input modes.
    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_ELEMENT = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BREAKDOWN = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // Datapath operations.
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_RESTART    = 4'd1;
    localparam logic [3:0] OP_HOLD       = 4'd2;
    localparam logic [3:0] OP_LOAD       = 4'd3;
    localparam logic [3:0] OP_ROT        = 4'd4;
    localparam logic [3:0] OP_SQ         = 4'd5;
    localparam logic [3:0] OP_SQRT       = 4'd6;
    localparam logic [3:0] OP_DIV_INIT_C = 4'd7;
    localparam logic [3:0] OP_DIV_INIT_S = 4'd8;
    localparam logic [3:0] OP_DIV_STEP   = 4'd9;
    localparam logic [3:0] OP_DIV_END_C  = 4'd10;
    localparam logic [3:0] OP_DIV_END_S  = 4'd11;
    localparam logic [3:0] OP_SAVE       = 4'd12;

    // Kinds of result loaded into the output register.
    localparam logic [1:0] KIND_ELEM = 2'd0;
    localparam logic [1:0] KIND_COL  = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    // Last steps of one rotation, the squaring sequence, the square root and the divider.
    localparam int ROT_LAST_STEP  = 5;
    localparam int SQ_LAST_STEP   = 2;
    localparam int SQRT_LAST_STEP = 31;
    localparam int DIV_LAST_STEP  = 32;

    // Command from controller to datapath.
    typedef struct packed {
        logic [3:0] op;
        logic [4:0] iter;
        logic       load;
        logic [1:0] kind;
        logic [4:0] row;
    } ghc_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic r_zero;
    } ghc_stat_t;

endpackage

[rtl/givens_hessenberg_column_update.sv]
// Channel  Handshake              Payload
// req      req_valid, req_ready   req   (ghc_pkg::ghc_in_t: mode, value)
// rsp      rsp_valid, rsp_ready   rsp   (ghc_pkg::ghc_out_t)
//
// One item is worked on at a time. A restart or the first element of a
// column needs only to be taken; a refused element goes on to the output.
// An inner element is taken, goes through one rotation on the shared
// 32x32 multiplier and is output. A column-closing element is taken, then
// passes through the squares, the bit-pair square root, the two quotients,
// a rotation, the store of the new rotation, a second rotation and the
// output; on a zero norm the quotients are skipped.
// Reset clears the rotation count, element index, carried value and e.
// A finished result waits in the output register while the next item is
// taken; only a second result stalls behind an unread one.
`include "givens_hessenberg_column_update_assert.svh"

module givens_hessenberg_column_update #(
    parameter int RESTART_LEN = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ghc_pkg::ghc_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ghc_pkg::ghc_out_t rsp
);

    localparam int CW = $clog2(RESTART_LEN + 1);

    ghc_pkg::ghc_cmd_t  cmd;
    ghc_pkg::ghc_stat_t stat;
    logic [CW-1:0]      count;
    logic [CW-1:0]      index;
    logic               dp_busy;

    ghc_ctrl #(
        .RESTART_LEN (RESTART_LEN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_mode  (req.mode),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd),
        .count     (count),
        .index     (index)
    );

    ghc_datapath #(
        .RESTART_LEN (RESTART_LEN)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .count (count),
        .index (index),
        .stat  (stat),
        .rsp   (rsp)
    );

    // The datapath is in the middle of a multi-cycle operation.
    assign dp_busy = cmd.op == ghc_pkg::OP_ROT || cmd.op == ghc_pkg::OP_SQRT
                  || cmd.op == ghc_pkg::OP_DIV_STEP;

    // A result is never loaded over one that has not been taken.
    `GHC_ASSERT_SAME(a_no_overwrite, cmd.load, !rsp_valid || rsp_ready, "result overwritten")
    // A loaded result is offered in the next cycle.
    `GHC_ASSERT_NEXT(a_load_shows, cmd.load, rsp_valid, "loaded result not offered")
    // While the datapath is busy no new item is taken.
    `GHC_ASSERT_SAME(a_busy_not_ready, dp_busy, !req_ready, "item taken while busy")
    // The element index never passes the rotation count by more than one.
    `GHC_ASSERT_SAME(a_index_range, 1'b1, index <= count + CW'(1), "element index out of range")

endmodule

[rtl/ghc_ctrl.sv]
module ghc_ctrl #(
    parameter int RESTART_LEN = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic                                   req_mode,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    input  ghc_pkg::ghc_stat_t                     stat,
    output ghc_pkg::ghc_cmd_t                      cmd,
    output logic [$clog2(RESTART_LEN + 1) - 1:0]  count,
    output logic [$clog2(RESTART_LEN + 1) - 1:0]  index
);

    localparam int CW = $clog2(RESTART_LEN + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DIVC = 3'd4;
    localparam logic [2:0] S_DIVS = 3'd5;
    localparam logic [2:0] S_SAVE = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [1:0] PH_ELEM = 2'd0;
    localparam logic [1:0] PH_PAIR = 2'd1;
    localparam logic [1:0] PH_RHS  = 2'd2;

    logic [2:0]    state_reg, state_next;
    logic [5:0]    step_reg, step_next;
    logic [1:0]    phase_reg, phase_next;
    logic [1:0]    kind_reg, kind_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] index_reg, index_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] index_m1;
    logic          accept;

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign index_m1  = index_reg - CW'(1);
    assign rsp_valid = out_valid_reg;
    assign count     = count_reg;
    // The rotation store is read at the index of the coming cycle, so its
    // registered output is ready as soon as the next element is taken.
    assign index     = index_next;

    // Sequencer for one item.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        count_next = count_reg;
        index_next = index_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.op     = ghc_pkg::OP_NONE;
        cmd.iter   = step_reg[4:0];
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                step_next = '0;
                if (accept)
                begin
                    if (req_mode == ghc_pkg::MODE_RESTART)
                    begin
                        cmd.op     = ghc_pkg::OP_RESTART;
                        count_next = '0;
                        index_next = '0;
                    end
                    else if (count_reg >= CW'(RESTART_LEN))
                    begin
                        kind_next  = ghc_pkg::KIND_FULL;
                        state_next = S_OUT;
                    end
                    else if (index_reg == '0)
                    begin
                        cmd.op     = ghc_pkg::OP_HOLD;
                        index_next = CW'(1);
                    end
                    else
                    begin
                        cmd.op = ghc_pkg::OP_LOAD;
                        if (index_reg <= count_reg)
                        begin
                            phase_next = PH_ELEM;
                            state_next = S_ROT;
                        end
                        else
                        begin
                            state_next = S_SQ;
                        end
                    end
                end
            end
            S_ROT:
            begin
                cmd.op = ghc_pkg::OP_ROT;
                if (step_reg == 6'(ghc_pkg::ROT_LAST_STEP))
                begin
                    step_next = '0;
                    unique case (phase_reg)
                        PH_ELEM:
                        begin
                            kind_next  = ghc_pkg::KIND_ELEM;
                            state_next = S_OUT;
                        end
                        PH_PAIR:
                        begin
                            state_next = S_SAVE;
                        end
                        default:
                        begin
                            kind_next  = ghc_pkg::KIND_COL;
                            state_next = S_OUT;
                        end
                    endcase
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            S_SQ:
            begin
                cmd.op = ghc_pkg::OP_SQ;
                if (step_reg == 6'(ghc_pkg::SQ_LAST_STEP))
                begin
                    step_next  = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            S_SQRT:
            begin
                cmd.op = ghc_pkg::OP_SQRT;
                if (step_reg == 6'(ghc_pkg::SQRT_LAST_STEP))
                begin
                    step_next  = '0;
                    state_next = S_DIVC;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            S_DIVC, S_DIVS:
            begin
                // A zero norm needs no quotient: the identity rotation is set at once.
                priority if (step_reg == 6'(ghc_pkg::DIV_LAST_STEP) || stat.r_zero)
                begin
                    cmd.op = (state_reg == S_DIVC) ? ghc_pkg::OP_DIV_END_C
                                                   : ghc_pkg::OP_DIV_END_S;
                end
                else if (step_reg == '0)
                begin
                    cmd.op = (state_reg == S_DIVC) ? ghc_pkg::OP_DIV_INIT_C
                                                   : ghc_pkg::OP_DIV_INIT_S;
                end
                else
                begin
                    cmd.op = ghc_pkg::OP_DIV_STEP;
                end
                if (step_reg == 6'(ghc_pkg::DIV_LAST_STEP) || stat.r_zero)
                begin
                    step_next = '0;
                    if (state_reg == S_DIVC)
                    begin
                        state_next = S_DIVS;
                    end
                    else
                    begin
                        phase_next = PH_PAIR;
                        state_next = S_ROT;
                    end
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            S_SAVE:
            begin
                cmd.op     = ghc_pkg::OP_SAVE;
                phase_next = PH_RHS;
                step_next  = '0;
                state_next = S_ROT;
            end
            default:
            begin
                // Wait for the output register to be free.
                cmd.kind = kind_reg;
                unique case (kind_reg)
                    ghc_pkg::KIND_ELEM: cmd.row = 5'(index_m1);
                    ghc_pkg::KIND_COL:  cmd.row = 5'(count_reg);
                    default:            cmd.row = '0;
                endcase
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                    if (kind_reg == ghc_pkg::KIND_ELEM)
                    begin
                        index_next = index_reg + CW'(1);
                    end
                    else if (kind_reg == ghc_pkg::KIND_COL)
                    begin
                        count_next = count_reg + CW'(1);
                        index_next = '0;
                    end
                end
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            phase_reg     <= PH_ELEM;
            kind_reg      <= ghc_pkg::KIND_ELEM;
            count_reg     <= '0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/ghc_datapath.sv]
module ghc_datapath #(
    parameter int RESTART_LEN = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ghc_pkg::ghc_cmd_t                      cmd,
    input  ghc_pkg::ghc_in_t                       req,
    input  logic [$clog2(RESTART_LEN + 1) - 1:0]  count,
    input  logic [$clog2(RESTART_LEN + 1) - 1:0]  index,
    output ghc_pkg::ghc_stat_t                     stat,
    output ghc_pkg::ghc_out_t                      rsp
);

    localparam int CW = $clog2(RESTART_LEN + 1);
    localparam int AW = (RESTART_LEN > 1) ? $clog2(RESTART_LEN) : 1;

    // Rotation store: cosine in the upper half, sine in the lower half.
    logic [63:0] rot_mem [RESTART_LEN];
    logic [63:0] rot_rd_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    logic signed [31:0] x_reg, y_reg, c_reg, s_reg;
    logic signed [31:0] hi_reg, lo_reg, ent_reg;
    logic signed [31:0] carry_reg, rhs_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic [63:0]        n_reg, res_reg;
    logic [31:0]        rem_reg;
    logic [30:0]        num_reg;
    logic [30:0]        quo_reg;
    ghc_pkg::ghc_out_t  out_reg;
    ghc_pkg::ghc_out_t  out_next;

    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] div_src;
    logic [31:0]        div_mag;
    logic [62:0]        div_num;
    logic [31:0]        r_val;
    logic [32:0]        div_t;
    logic [5:0]         sqrt_sh;
    logic [63:0]        sqrt_bit, sqrt_t;
    logic [30:0]        lo_abs;
    logic [CW-1:0]      index_m1;

    assign index_m1 = index - CW'(1);
    assign raddr    = AW'(index_m1);
    assign waddr    = AW'(count);
    assign r_val    = res_reg[31:0];
    assign stat.r_zero = (r_val == '0);
    assign rsp      = out_reg;

    // Q18.46 to Q16.16 with rounding half away from zero and saturation.
    function automatic logic signed [31:0] narrow(input logic signed [63:0] p);
        logic        neg;
        logic [63:0] m;
        logic [63:0] q;
        neg = p[63];
        m   = neg ? 64'(-p) : 64'(p);
        q   = (m + 64'd536870912) >> 30;
        if (!neg)
        begin
            return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
        end
        return (q > 64'h8000_0000) ? 32'sh8000_0000 : -32'(q);
    endfunction

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = x_reg;
        mul_b = x_reg;
        if (cmd.op == ghc_pkg::OP_ROT)
        begin
            unique case (cmd.iter)
                5'd0:    begin mul_a = c_reg; mul_b = x_reg; end
                5'd1:    begin mul_a = s_reg; mul_b = y_reg; end
                5'd2:    begin mul_a = s_reg; mul_b = x_reg; end
                default: begin mul_a = c_reg; mul_b = y_reg; end
            endcase
        end
        else if (cmd.iter != 5'd0)
        begin
            mul_a = y_reg;
            mul_b = y_reg;
        end
    end

    // Divider set-up: magnitude of the numerator scaled to Q2.30 plus half r.
    assign div_src = (cmd.op == ghc_pkg::OP_DIV_INIT_C) ? x_reg : y_reg;
    assign div_mag = div_src[31] ? 32'(-div_src) : 32'(div_src);
    assign div_num = {1'b0, div_mag, 30'b0} + 63'(r_val >> 1);
    assign div_t   = {rem_reg, num_reg[30]};

    // Square root trial bit, from bit 62 down in steps of two.
    assign sqrt_sh  = 6'd62 - {cmd.iter, 1'b0};
    assign sqrt_bit = 64'd1 << sqrt_sh;
    assign sqrt_t   = res_reg + sqrt_bit;

    assign lo_abs = (lo_reg == 32'sh8000_0000) ? 31'h7FFF_FFFF
                  : (lo_reg[31] ? 31'(-lo_reg) : 31'(lo_reg));

    // Rotation store, written on column end and read through a register.
    always_ff @(posedge clk)
    begin
        if (cmd.op == ghc_pkg::OP_SAVE)
        begin
            rot_mem[waddr] <= {c_reg, s_reg};
        end
        rot_rd_reg <= rot_mem[raddr];
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            ghc_pkg::OP_LOAD:
            begin
                x_reg <= carry_reg;
                y_reg <= req.value;
                c_reg <= rot_rd_reg[63:32];
                s_reg <= rot_rd_reg[31:0];
            end
            ghc_pkg::OP_ROT:
            begin
                prod_reg <= mul_a * mul_b;
                unique case (cmd.iter)
                    5'd0: ;
                    5'd1: acc_reg <= prod_reg;
                    5'd2: acc_reg <= acc_reg - prod_reg;
                    5'd3:
                    begin
                        hi_reg  <= narrow(acc_reg);
                        acc_reg <= prod_reg;
                    end
                    5'd4: acc_reg <= acc_reg + prod_reg;
                    default: lo_reg <= narrow(acc_reg);
                endcase
            end
            ghc_pkg::OP_SQ:
            begin
                prod_reg <= mul_a * mul_b;
                if (cmd.iter == 5'd1)
                begin
                    n_reg <= 64'(prod_reg);
                end
                else if (cmd.iter == 5'd2)
                begin
                    n_reg   <= n_reg + 64'(prod_reg);
                    res_reg <= '0;
                end
            end
            ghc_pkg::OP_SQRT:
            begin
                if (n_reg >= sqrt_t)
                begin
                    n_reg   <= n_reg - sqrt_t;
                    res_reg <= (res_reg >> 1) + sqrt_bit;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            ghc_pkg::OP_DIV_INIT_C, ghc_pkg::OP_DIV_INIT_S:
            begin
                rem_reg <= div_num[62:31];
                num_reg <= div_num[30:0];
                quo_reg <= '0;
            end
            ghc_pkg::OP_DIV_STEP:
            begin
                if (div_t >= {1'b0, r_val})
                begin
                    rem_reg <= 32'(div_t - {1'b0, r_val});
                    quo_reg <= {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_t[31:0];
                    quo_reg <= {quo_reg[29:0], 1'b0};
                end
                num_reg <= {num_reg[29:0], 1'b0};
            end
            ghc_pkg::OP_DIV_END_C:
            begin
                if (stat.r_zero)
                begin
                    c_reg <= 32'sh4000_0000;
                end
                else
                begin
                    c_reg <= x_reg[31] ? -{1'b0, quo_reg} : {1'b0, quo_reg};
                end
            end
            ghc_pkg::OP_DIV_END_S:
            begin
                if (stat.r_zero)
                begin
                    s_reg <= '0;
                end
                else
                begin
                    s_reg <= y_reg[31] ? {1'b0, quo_reg} : -{1'b0, quo_reg};
                end
            end
            ghc_pkg::OP_SAVE:
            begin
                ent_reg <= hi_reg;
                x_reg   <= rhs_reg;
                y_reg   <= '0;
            end
            default: ;
        endcase
    end

    // Carried value and the live entry of e.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            rhs_reg   <= '0;
        end
        else
        begin
            if (cmd.op == ghc_pkg::OP_RESTART)
            begin
                carry_reg <= '0;
                rhs_reg   <= req.value;
            end
            else if (cmd.op == ghc_pkg::OP_HOLD)
            begin
                carry_reg <= req.value;
            end
            else if (cmd.load && cmd.kind == ghc_pkg::KIND_ELEM)
            begin
                carry_reg <= lo_reg;
            end
            else if (cmd.load && cmd.kind == ghc_pkg::KIND_COL)
            begin
                carry_reg <= '0;
                rhs_reg   <= lo_reg;
            end
        end
    end

    // Next content of the output register.
    always_comb
    begin
        out_next = out_reg;
        if (cmd.load)
        begin
            out_next     = '0;
            out_next.row = cmd.row;
            unique case (cmd.kind)
                ghc_pkg::KIND_ELEM:
                begin
                    out_next.entry = hi_reg;
                end
                ghc_pkg::KIND_COL:
                begin
                    out_next.entry      = ent_reg;
                    out_next.rhs_entry  = hi_reg;
                    out_next.residual   = lo_abs;
                    out_next.column_end = 1'b1;
                    out_next.status     = stat.r_zero ? ghc_pkg::STATUS_BREAKDOWN
                                                      : ghc_pkg::STATUS_OK;
                end
                default:
                begin
                    out_next.status = ghc_pkg::STATUS_FULL;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
